@@ design/sorted_interval_map_core_macros.svh @@
// assertion macros for the sorted interval map core
// used by sorted_interval_map_core.sv, expects a clock and reset in scope
`ifndef SORTED_INTERVAL_MAP_CORE_MACROS_SVH
`define SORTED_INTERVAL_MAP_CORE_MACROS_SVH

`define SIMAP_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

`define SIMAP_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`define SIMAP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/simap_pkg.sv @@
// shared types and codes for the sorted interval map core
// no dependencies
package simap_pkg;

   localparam logic [1:0] FUNC_GET    = 2'd0;
   localparam logic [1:0] FUNC_PUT    = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_BAD  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] start_pos;
      logic signed [31:0] end_pos;
      logic [31:0]        entry_value;
      logic [31:0]        default_value;
   } req_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic        found;
      logic [1:0]  status;
   } rsp_type;

endpackage

@@ design/sorted_interval_map_core.sv @@
// sorted interval map core: sorted table of disjoint ranges with value words
// depends on simap_pkg and sorted_interval_map_core_macros.svh
//
// One request at a time; req_ready is high only while the block is idle. The table lives
// in one memory holding two banks: a put or remove streams the current bank through a
// single compare unit, one stored range per step, and writes the rebuilt table into the
// other bank, then swaps banks. For each stored range a put or remove runs one registered
// memory read, a split step, then one write slot each for the left piece, the new range
// and the right piece; a get scans linearly, one memory read and one compare step per
// range, until a hit. The memory has a single read port and a single write port. There is
// no clearing pass after reset; the table is empty then.
`include "sorted_interval_map_core_macros.svh"

module sorted_interval_map_core
   import simap_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int POS_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int MEM_DEPTH = 2 ** (AW + 1);
   localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] lo_pos;
      logic signed [POS_WIDTH-1:0] hi_pos;
      logic [VALUE_WIDTH-1:0]      word;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_SIZE, S_RD, S_GET, S_SPLIT, S_EMIT_L, S_EMIT_N, S_EMIT_R,
      S_TAIL, S_FLUSH, S_DONE
   } state_type;

   entry_type mem [MEM_DEPTH];
   entry_type rd_data_ff;
   logic [AW:0] rd_addr, wr_addr;
   logic mem_we;
   entry_type mem_wdata;

   state_type state_ff, state_in;
   logic bank_ff, bank_in;
   logic [CW-1:0] count_ff, count_in, rd_idx_ff, rd_idx_in, wcnt_ff, wcnt_in;
   logic [1:0] mode_ff, func_ff, func_in;
   logic signed [POS_WIDTH-1:0] first_ff, first_in, last_ff, last_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in, dflt_ff, dflt_in;
   logic [VALUE_WIDTH-1:0] result_ff, result_in;
   logic found_ff, found_in;
   logic [1:0] status_ff, status_in;
   entry_type pend_ff, pend_in, left_ff, left_in, right_ff, right_in;
   logic pend_vld_ff, pend_vld_in, pend_new_ff, pend_new_in;
   logic left_vld_ff, left_vld_in, right_vld_ff, right_vld_in;
   logic new_here_ff, new_here_in, new_done_ff, new_done_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic emit_en, emit_new;
   entry_type emit_item, new_item;
   logic signed [63:0] start_ext, end_ext;
   logic [CW:0] need_total;
   logic last_entry;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rd_addr   = {bank_ff, rd_idx_ff[AW-1:0]};
   assign wr_addr   = {~bank_ff, wcnt_ff[AW-1:0]};
   assign start_ext = 64'(req_data.start_pos);
   assign end_ext   = 64'(req_data.end_pos);
   assign last_entry = ((rd_idx_ff + CW'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      bank_in = bank_ff;
      count_in = count_ff;
      rd_idx_in = rd_idx_ff;
      wcnt_in = wcnt_ff;
      func_in = func_ff;
      first_in = first_ff;
      last_in = last_ff;
      val_in = val_ff;
      dflt_in = dflt_ff;
      result_in = result_ff;
      found_in = found_ff;
      status_in = status_ff;
      pend_in = pend_ff;
      pend_vld_in = pend_vld_ff;
      pend_new_in = pend_new_ff;
      left_in = left_ff;
      left_vld_in = left_vld_ff;
      right_in = right_ff;
      right_vld_in = right_vld_ff;
      new_here_in = new_here_ff;
      new_done_in = new_done_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      mem_we = 1'b0;
      mem_wdata = pend_ff;
      emit_en = 1'b0;
      emit_new = 1'b0;
      new_item = '{lo_pos: first_ff, hi_pos: last_ff, word: val_ff};
      emit_item = new_item;
      need_total = (CW+1)'(count_ff) + (CW+1)'((func_ff == FUNC_PUT) ? 2 : 1);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in = req_data.func;
               first_in = start_ext[POS_WIDTH-1:0];
               last_in = end_ext[POS_WIDTH-1:0];
               val_in = 64'(req_data.entry_value) >> 0 == 0 ? '0 :
                        VALUE_WIDTH'(64'(req_data.entry_value));
               dflt_in = VALUE_WIDTH'(64'(req_data.default_value));
               result_in = '0;
               found_in = 1'b0;
               status_in = STATUS_OK;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            rd_idx_in = '0;
            wcnt_in = '0;
            pend_vld_in = 1'b0;
            pend_new_in = 1'b0;
            new_done_in = (func_ff != FUNC_PUT);
            case (func_ff)
               FUNC_GET: begin
                  result_in = dflt_ff;
                  state_in = (count_ff == '0) ? S_DONE : S_RD;
               end
               FUNC_CLEAR: begin
                  count_in = '0;
                  state_in = S_DONE;
               end
               default: begin
                  if (first_ff > last_ff) begin
                     status_in = STATUS_BAD;
                     state_in = S_DONE;
                  end else if ((mode_ff[1] && first_ff == POS_MAX) ||
                               (mode_ff[0] && last_ff == POS_MAX)) begin
                     status_in = STATUS_BAD;
                     state_in = S_DONE;
                  end else begin
                     first_in = first_ff + POS_WIDTH'(mode_ff[1]);
                     last_in = last_ff + POS_WIDTH'(mode_ff[0]);
                     state_in = S_SIZE;
                  end
               end
            endcase
         end
         S_SIZE: begin
            if (first_ff >= last_ff) begin
               state_in = S_DONE;
            end else if (need_total > (CW+1)'(TABLE_DEPTH)) begin
               status_in = STATUS_FULL;
               state_in = S_DONE;
            end else begin
               state_in = (count_ff == '0) ? S_TAIL : S_RD;
            end
         end
         S_RD: begin
            state_in = (func_ff == FUNC_GET) ? S_GET : S_SPLIT;
         end
         S_GET: begin
            if (first_ff >= rd_data_ff.lo_pos && first_ff < rd_data_ff.hi_pos) begin
               found_in = 1'b1;
               result_in = rd_data_ff.word;
               state_in = S_DONE;
            end else begin
               rd_idx_in = rd_idx_ff + CW'(1);
               state_in = last_entry ? S_DONE : S_RD;
            end
         end
         S_SPLIT: begin
            left_vld_in = (rd_data_ff.lo_pos < first_ff);
            left_in = rd_data_ff;
            if (rd_data_ff.hi_pos > first_ff) begin
               left_in.hi_pos = first_ff;
            end
            right_vld_in = (rd_data_ff.hi_pos > last_ff);
            right_in = rd_data_ff;
            if (rd_data_ff.lo_pos < last_ff) begin
               right_in.lo_pos = last_ff;
            end
            new_here_in = !new_done_ff && (rd_data_ff.hi_pos > last_ff);
            state_in = S_EMIT_L;
         end
         S_EMIT_L: begin
            emit_en = left_vld_ff;
            emit_item = left_ff;
            state_in = S_EMIT_N;
         end
         S_EMIT_N: begin
            emit_en = new_here_ff;
            emit_new = 1'b1;
            if (new_here_ff) begin
               new_done_in = 1'b1;
            end
            state_in = S_EMIT_R;
         end
         S_EMIT_R: begin
            emit_en = right_vld_ff;
            emit_item = right_ff;
            rd_idx_in = rd_idx_ff + CW'(1);
            state_in = last_entry ? S_TAIL : S_RD;
         end
         S_TAIL: begin
            emit_en = !new_done_ff;
            emit_new = 1'b1;
            new_done_in = 1'b1;
            state_in = S_FLUSH;
         end
         S_FLUSH: begin
            mem_we = pend_vld_ff;
            count_in = wcnt_ff + CW'(pend_vld_ff);
            pend_vld_in = 1'b0;
            bank_in = ~bank_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.result_value = 32'(64'(result_ff));
               rsp_data_in.found = found_ff;
               rsp_data_in.status = status_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // merge with the neighbor held back, or retire it to the other bank
      if (emit_en) begin
         if (!pend_vld_ff) begin
            pend_in = emit_item;
            pend_vld_in = 1'b1;
            pend_new_in = emit_new;
         end else if (emit_new && pend_ff.word == val_ff && pend_ff.hi_pos == first_ff) begin
            pend_in.hi_pos = last_ff;
            pend_new_in = 1'b1;
         end else if (!emit_new && pend_new_ff && emit_item.word == val_ff &&
                      emit_item.lo_pos == last_ff) begin
            pend_in.hi_pos = emit_item.hi_pos;
            pend_new_in = 1'b0;
         end else begin
            mem_we = 1'b1;
            wcnt_in = wcnt_ff + CW'(1);
            pend_in = emit_item;
            pend_new_in = emit_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bank_ff <= 1'b0;
         count_ff <= '0;
         mode_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         pend_new_ff <= 1'b0;
         new_done_ff <= 1'b0;
         rd_idx_ff <= '0;
         wcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         bank_ff <= bank_in;
         count_ff <= count_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         pend_vld_ff <= pend_vld_in;
         pend_new_ff <= pend_new_in;
         new_done_ff <= new_done_in;
         rd_idx_ff <= rd_idx_in;
         wcnt_ff <= wcnt_in;
      end
      func_ff <= func_in;
      first_ff <= first_in;
      last_ff <= last_in;
      val_ff <= val_in;
      dflt_ff <= dflt_in;
      result_ff <= result_in;
      found_ff <= found_in;
      status_ff <= status_in;
      pend_ff <= pend_in;
      left_ff <= left_in;
      left_vld_ff <= left_vld_in;
      right_ff <= right_in;
      right_vld_ff <= right_vld_in;
      new_here_ff <= new_here_in;
      rsp_data_ff <= rsp_data_in;
   end

   `SIMAP_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(TABLE_DEPTH), "entry count over depth")
   `SIMAP_ASSERT_IMPLY(a_write_bound, mem_we, wcnt_ff < CW'(TABLE_DEPTH), "write past table end")
   `SIMAP_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready while busy")
   `SIMAP_ASSERT_IMPLY(a_found_ok, rsp_valid && rsp_data.found, rsp_data.status == STATUS_OK,
      "found with error status")

endmodule

@@ test/tb_top.sv @@
// testbench for sorted_interval_map_core: random and directed get/put/remove/clear traffic
// holds a scoreboard class with its own range table predictor; depends on simap_pkg
`timescale 1ns / 1ps

module tb_top;
   import simap_pkg::*;

   localparam int DEPTH = 64;
   localparam int IDLE_LIMIT = 20000;
   localparam longint POS_TOP = 64'sd2147483647;

   class range_table_board;
      longint starts[DEPTH];
      longint ends[DEPTH];
      logic [31:0] vals[DEPTH];
      int count;
      logic [1:0] mode;
      rsp_type pending[$];
      int errors;

      function void wipe();
         count = 0;
         mode = 0;
         errors = 0;
         pending.delete();
      endfunction

      function void insert_at(int idx, longint s, longint e, logic [31:0] v);
         if (count >= DEPTH || idx > count) return;
         for (int k = count; k > idx; k--) begin
            starts[k] = starts[k-1];
            ends[k] = ends[k-1];
            vals[k] = vals[k-1];
         end
         starts[idx] = s;
         ends[idx] = e;
         vals[idx] = v;
         count++;
      endfunction

      function void delete_at(int idx);
         if (idx >= count) return;
         for (int k = idx; k < count - 1; k++) begin
            starts[k] = starts[k+1];
            ends[k] = ends[k+1];
            vals[k] = vals[k+1];
         end
         count--;
      endfunction

      function void overwrite(longint first, longint last, logic [31:0] v, bit add);
         int i;
         int ins;
         bit have;
         longint s;
         longint e;
         i = 0;
         ins = 0;
         have = 0;
         while (i < count) begin
            s = starts[i];
            e = ends[i];
            if (s >= first && !have) begin
               ins = i;
               have = 1;
            end
            if (e < first) begin
               i++;
               continue;
            end
            if (s > last) break;
            if (s < first && e <= last) begin
               ends[i] = first;
               i++;
            end else if (s < first) begin
               ends[i] = first;
               insert_at(i + 1, last, e, vals[i]);
               i++;
            end else if (e > last) begin
               starts[i] = last;
               i++;
            end else begin
               delete_at(i);
            end
         end
         if (!add) return;
         if (!have) ins = i;
         insert_at(ins, first, last, v);
         if (ins > 0 && vals[ins-1] == v && ends[ins-1] == first) begin
            ends[ins-1] = last;
            delete_at(ins);
            ins--;
            first = starts[ins];
         end
         if (ins + 1 < count && vals[ins+1] == v && starts[ins+1] == last) begin
            starts[ins+1] = first;
            delete_at(ins);
         end
      endfunction

      function void note_request(req_type r);
         rsp_type o;
         longint first;
         longint last;
         bit bf;
         bit bl;
         int need;
         o = '0;
         first = longint'(r.start_pos);
         last = longint'(r.end_pos);
         if (r.func == FUNC_GET) begin
            o.result_value = r.default_value;
            for (int k = 0; k < count; k++) begin
               if (first >= starts[k] && first < ends[k]) begin
                  o.result_value = vals[k];
                  o.found = 1'b1;
               end
            end
         end else if (r.func == FUNC_CLEAR) begin
            count = 0;
         end else if (first > last) begin
            o.status = STATUS_BAD;
         end else begin
            bf = (mode == 2 || mode == 3);
            bl = (mode == 1 || mode == 3);
            if ((bf && first == POS_TOP) || (bl && last == POS_TOP)) begin
               o.status = STATUS_BAD;
            end else begin
               if (bf) first++;
               if (bl) last++;
               if (first < last) begin
                  need = (r.func == FUNC_PUT) ? 2 : 1;
                  if (count + need > DEPTH) o.status = STATUS_FULL;
                  else overwrite(first, last, r.entry_value, r.func == FUNC_PUT);
               end
            end
         end
         pending.push_back(o);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.result_value !== want.result_value) begin
            $display("%0t: result_value expected %h actual %h", $time, want.result_value,
                     got.result_value);
            errors++;
         end
         if (got.found !== want.found) begin
            $display("%0t: found expected %b actual %b", $time, want.found, got.found);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_wr_en;
   logic [1:0] csr_wr_data;

   range_table_board board;
   int idle_cycles;
   int burst_left;

   sorted_interval_map_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         case ($urandom_range(0, 3))
            0: rsp_ready <= 1'b0;
            1: rsp_ready <= ($urandom_range(0, 9) < 3);
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic send_request(req_type r);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic send_op(logic [1:0] f, int s, int e, logic [31:0] v, logic [31:0] d);
      req_type r;
      r.func = f;
      r.start_pos = s;
      r.end_pos = e;
      r.entry_value = v;
      r.default_value = d;
      send_request(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (700) @(posedge clock);
   endtask

   task automatic write_mode(logic [1:0] m);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.mode = m;
   endtask

   function automatic int pick_pos(int lo_span);
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff - $urandom_range(0, 3);
         1: return 32'h80000000 + $urandom_range(0, 3);
         2: return $urandom;
         default: return $urandom_range(0, lo_span);
      endcase
   endfunction

   task automatic random_phase(int n, int span);
      req_type r;
      int a;
      int b;
      for (int k = 0; k < n; k++) begin
         r.entry_value = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3);
         r.default_value = $urandom;
         a = pick_pos(span);
         b = ($urandom_range(0, 7) == 0) ? pick_pos(span) : a + $urandom_range(0, span / 4);
         if (b < a && $urandom_range(0, 3) != 0) b = a;
         r.start_pos = a;
         r.end_pos = b;
         case ($urandom_range(0, 19))
            0: r.func = FUNC_CLEAR;
            1, 2, 3, 4, 5, 6, 7: r.func = FUNC_GET;
            8, 9, 10: r.func = FUNC_REMOVE;
            default: r.func = FUNC_PUT;
         endcase
         if (r.func == FUNC_CLEAR && board.count < 40 && $urandom_range(0, 1)) r.func = FUNC_PUT;
         send_request(r);
      end
   endtask

   initial begin
      board = new();
      board.wipe();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      idle_cycles = 0;
      burst_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_op(FUNC_GET, 5, 0, 0, 32'hffffffff);
      send_op(FUNC_PUT, 10, 20, 32'h1, 0);
      send_op(FUNC_PUT, 20, 30, 32'h1, 0);
      send_op(FUNC_PUT, 0, 10, 32'h1, 0);
      send_op(FUNC_PUT, 12, 15, 32'h2, 0);
      send_op(FUNC_GET, 13, 0, 0, 32'hdead);
      send_op(FUNC_GET, 15, 0, 0, 32'hdead);
      send_op(FUNC_REMOVE, 5, 25, 0, 0);
      send_op(FUNC_PUT, 9, 3, 32'h5, 0);
      send_op(FUNC_PUT, 7, 7, 32'h5, 0);
      send_op(FUNC_PUT, 32'h80000000, 32'h7fffffff, 32'hffffffff, 0);
      send_op(FUNC_GET, 32'h80000000, 32'h7fffffff, 0, 0);
      send_op(FUNC_PUT, -100, 100, 32'h0, 0);
      send_op(FUNC_GET, 32'h7ffffffe, 0, 0, 32'h1234);
      send_op(FUNC_CLEAR, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_op(FUNC_GET, 0, 0, 0, 32'h55aa55aa);
      for (int k = 0; k < 33; k++) send_op(FUNC_PUT, 4 * k, 4 * k + 1, k, 0);
      send_op(FUNC_PUT, 1, 2, 32'hff, 0);
      send_op(FUNC_REMOVE, 2, 2, 0, 0);
      send_op(FUNC_REMOVE, 1, 202, 0, 0);
      drain();
      for (int m = 1; m < 4; m++) begin
         write_mode(m[1:0]);
         send_op(FUNC_PUT, 32'h7fffffff, 32'h7fffffff, 1, 0);
         send_op(FUNC_PUT, 3, 3, 7, 0);
         send_op(FUNC_GET, 3, 0, 0, 9);
         send_op(FUNC_GET, 4, 0, 0, 9);
         drain();
      end

      for (int p = 0; p < 8; p++) begin
         write_mode(2'($urandom_range(0, 3)));
         random_phase(110, (p % 2) ? 60 : 1000);
         drain();
      end
      write_mode(2'd0);
      random_phase(60, 100);
      drain();
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/simap_pkg.sv
design/sorted_interval_map_core.sv
test/tb_top.sv
